// ===== sv/gbp_pkg.sv =====
// Shared types and codes for the gshare branch predictor.
`timescale 1ns / 1ps

package gbp_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic clearing;
    logic in_stall;
    logic rd_en;
    logic exec_fire;
  } ctl_t;

  localparam logic ACT_PREDICT = 1'b0;
  localparam logic ACT_UPDATE  = 1'b1;

  localparam logic [1:0] KIND_COND   = 2'd0;
  localparam logic [1:0] KIND_UNCOND = 2'd1;

  localparam logic [1:0] CTR_MIN         = 2'd0;
  localparam logic [1:0] CTR_WEAK_TAKEN  = 2'd2;
  localparam logic [1:0] CTR_MAX         = 2'd3;

endpackage

// ===== sv/gshare_branch_predictor.sv =====
// Top level of the gshare branch predictor with a direct-mapped target buffer.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid / in_stall) carries one item per handshake: a
// predict request (action 0) or an update with the resolved outcome (action 1).
// The output channel (out_valid / out_stall) returns one item for every
// predict request and nothing for an update.
// Each item reads the counter and target memories in the cycle it is accepted
// and is resolved in the execute state, when the registered read data arrives;
// an update writes the target memory then, and a conditional update also
// trains the counter. The next item is taken only after the last is resolved.
// A prediction is loaded into the output register as its item is resolved.
// The output register lets the next item be accepted while a result waits.
// If a prediction finds the output register still held by out_stall, the
// block waits with in_stall high until the register drains.
// After reset the block sweeps both memories to zero, one entry per cycle,
// over clear addresses 0 to max(TARGET_ENTRIES, COUNTER_ENTRIES) - 1, with
// in_stall high. The global history resets to zero.
// Table depths are to be powers of two; the block does not enforce this.

module gshare_branch_predictor #(
  parameter int TARGET_ENTRIES  = 1024,
  parameter int COUNTER_ENTRIES = 4096,
  parameter int HISTORY_BITS    = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [63:0] inst_addr,
  input  logic [1:0]  inst_kind,
  input  logic        was_taken,
  input  logic [63:0] next_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        predict_taken,
  output logic [63:0] predict_target
);

  localparam int CIDX_W = $clog2(COUNTER_ENTRIES);
  localparam int TIDX_W = $clog2(TARGET_ENTRIES);
  localparam int CLR_W  = (CIDX_W > TIDX_W) ? CIDX_W : TIDX_W;

  gbp_pkg::ctl_t ctl;
  logic [CLR_W-1:0] clr_addr;
  logic hold;

  logic [HISTORY_BITS-1:0] history;
  logic [HISTORY_BITS-1:0] history_next;

  logic              item_action;
  logic [1:0]        item_kind;
  logic              item_taken;
  logic [63:0]       item_next;
  logic [CIDX_W-1:0] item_cidx;
  logic [TIDX_W-1:0] item_tidx;

  logic [CIDX_W-1:0] rd_cidx;
  logic [TIDX_W-1:0] rd_tidx;
  logic [1:0]        ctr_rd;
  logic [63:0]       tgt_rd;

  logic              ctr_we;
  logic [CIDX_W-1:0] ctr_waddr;
  logic [1:0]        ctr_wdata;
  logic [1:0]        ctr_sat;
  logic              tgt_we;
  logic [TIDX_W-1:0] tgt_waddr;
  logic [63:0]       tgt_wdata;

  logic        pred_taken;
  logic        load_out;
  logic        out_valid_next;
  logic        train;

  gbp_ctrl #(
    .CLR_W(CLR_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .hold     (hold),
    .ctl      (ctl),
    .clr_addr (clr_addr)
  );

  assign in_stall = ctl.in_stall;
  assign rd_cidx  = inst_addr[CIDX_W-1:0] ^ CIDX_W'(history);
  assign rd_tidx  = inst_addr[TIDX_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      item_action <= action;
      item_kind   <= inst_kind;
      item_taken  <= was_taken;
      item_next   <= next_addr;
      item_cidx   <= rd_cidx;
      item_tidx   <= rd_tidx;
    end
  end

  gbp_ram #(
    .WIDTH(2),
    .DEPTH(COUNTER_ENTRIES)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .re    (ctl.rd_en),
    .raddr (rd_cidx),
    .rdata (ctr_rd)
  );

  gbp_ram #(
    .WIDTH(64),
    .DEPTH(TARGET_ENTRIES)
  ) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (tgt_waddr),
    .wdata (tgt_wdata),
    .re    (ctl.rd_en),
    .raddr (rd_tidx),
    .rdata (tgt_rd)
  );

  always_comb begin
    train = ctl.exec_fire && (item_action == gbp_pkg::ACT_UPDATE)
            && (item_kind == gbp_pkg::KIND_COND);

    if (item_taken) begin
      ctr_sat = (ctr_rd == gbp_pkg::CTR_MAX) ? ctr_rd : ctr_rd + 2'd1;
    end else begin
      ctr_sat = (ctr_rd == gbp_pkg::CTR_MIN) ? ctr_rd : ctr_rd - 2'd1;
    end

    if (ctl.clearing) begin
      ctr_we    = 1'b1;
      ctr_waddr = CIDX_W'(clr_addr);
      ctr_wdata = gbp_pkg::CTR_MIN;
      tgt_we    = 1'b1;
      tgt_waddr = TIDX_W'(clr_addr);
      tgt_wdata = '0;
    end else begin
      ctr_we    = train;
      ctr_waddr = item_cidx;
      ctr_wdata = ctr_sat;
      tgt_we    = ctl.exec_fire && (item_action == gbp_pkg::ACT_UPDATE);
      tgt_waddr = item_tidx;
      tgt_wdata = item_next;
    end

    history_next = train ? HISTORY_BITS'({history, item_taken}) : history;

    pred_taken = (item_kind == gbp_pkg::KIND_UNCOND) || (ctr_rd >= gbp_pkg::CTR_WEAK_TAKEN);
    hold       = (item_action == gbp_pkg::ACT_PREDICT) && out_valid && out_stall;
    load_out   = ctl.exec_fire && (item_action == gbp_pkg::ACT_PREDICT);
    out_valid_next = (out_valid && out_stall) || load_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history   <= '0;
      out_valid <= 1'b0;
    end else begin
      history   <= history_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      predict_taken  <= pred_taken;
      predict_target <= pred_taken ? tgt_rd : 64'd0;
    end
  end

endmodule

// ===== sv/gbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/gbp_ctrl.sv =====
// Sequencer for the gshare branch predictor: clearing sweep and item flow.
`timescale 1ns / 1ps

module gbp_ctrl #(
  parameter int CLR_W = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              hold,
  output gbp_pkg::ctl_t     ctl,
  output logic [CLR_W-1:0]  clr_addr
);

  gbp_pkg::state_t state;
  gbp_pkg::state_t state_next;
  logic [CLR_W-1:0] clr_addr_next;

  always_comb begin
    state_next = state;
    case (state)
      gbp_pkg::ST_CLEAR: begin
        if (clr_addr == {CLR_W{1'b1}}) begin
          state_next = gbp_pkg::ST_IDLE;
        end
      end
      gbp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = gbp_pkg::ST_EXEC;
        end
      end
      gbp_pkg::ST_EXEC: begin
        if (!hold) begin
          state_next = gbp_pkg::ST_IDLE;
        end
      end
      default: state_next = gbp_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl.clearing  = (state == gbp_pkg::ST_CLEAR);
    ctl.in_stall  = (state != gbp_pkg::ST_IDLE);
    ctl.rd_en     = (state == gbp_pkg::ST_IDLE) && in_valid;
    ctl.exec_fire = (state == gbp_pkg::ST_EXEC) && !hold;
    clr_addr_next = (state == gbp_pkg::ST_CLEAR) ? clr_addr + CLR_W'(1) : clr_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gbp_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

endmodule

// ===== sv/gbp_check.sv =====
// Port-level assertions for the gshare branch predictor, bound to the top level.
`timescale 1ns / 1ps

module gbp_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        action,
  input logic        out_valid,
  input logic        out_stall,
  input logic        predict_taken,
  input logic [63:0] predict_target
);

  a_stall_after_reset: assert property (@(posedge clk)
    $past(rst) |-> in_stall)
    else $error("Input channel open directly after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("A second item was accepted while one was in flight.");

  a_zero_target: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !predict_taken) |-> (predict_target == 64'd0))
    else $error("Not-taken prediction carries a nonzero target.");

  a_update_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && action && !out_valid) |-> ##2 !out_valid)
    else $error("An update item produced a result.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(predict_taken) && $stable(predict_target)))
    else $error("Stalled result changed or was dropped.");

endmodule

bind gshare_branch_predictor gbp_check u_gbp_check (.*);

// ===== bench/gshare_branch_predictor_tb.sv =====
// Self-checking testbench that drives the gshare branch predictor and checks every prediction.
`timescale 1ns / 1ps

module gshare_branch_predictor_tb;

  localparam int TARGET_ENTRIES  = 1024;
  localparam int COUNTER_ENTRIES = 4096;
  localparam int HISTORY_BITS    = 12;
  localparam int CIDX_W          = $clog2(COUNTER_ENTRIES);
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int LONG_HOLD       = 400;

  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct {
    bit        taken;
    bit [63:0] target;
  } prediction_t;

  class bp_scoreboard;
    bit [1:0]              counters[COUNTER_ENTRIES];
    bit [63:0]             targets[TARGET_ENTRIES];
    bit [HISTORY_BITS-1:0] history;
    prediction_t           pending[$];
    int                    errors;

    function new();
      foreach (counters[i]) counters[i] = gbp_pkg::CTR_MIN;
      foreach (targets[i]) targets[i] = '0;
      history = '0;
      errors = 0;
    endfunction

    function int unsigned counter_index(bit [63:0] addr);
      int unsigned low;
      low = addr[31:0] % COUNTER_ENTRIES;
      return (low ^ int'(history)) % COUNTER_ENTRIES;
    endfunction

    function void note_item(bit act, bit [63:0] addr, bit [1:0] kind, bit tk,
                            bit [63:0] dest);
      int unsigned ci;
      int unsigned ti;
      prediction_t p;
      ci = counter_index(addr);
      ti = addr[31:0] % TARGET_ENTRIES;
      if (act == gbp_pkg::ACT_PREDICT) begin
        p.taken = (kind == gbp_pkg::KIND_UNCOND) ||
                  (counters[ci] >= gbp_pkg::CTR_WEAK_TAKEN);
        p.target = p.taken ? targets[ti] : 64'h0;
        pending.push_back(p);
      end else begin
        targets[ti] = dest;
        if (kind == gbp_pkg::KIND_COND) begin
          if (tk && counters[ci] != gbp_pkg::CTR_MAX) begin
            counters[ci] = counters[ci] + 2'd1;
          end else if (!tk && counters[ci] != gbp_pkg::CTR_MIN) begin
            counters[ci] = counters[ci] - 2'd1;
          end
          history = {history[HISTORY_BITS-2:0], tk};
        end
      end
    endfunction

    function void check_result(bit taken, bit [63:0] target);
      prediction_t p;
      if (pending.size() == 0) begin
        $error("unexpected prediction: taken %0b target %h", taken, target);
        errors++;
        return;
      end
      p = pending.pop_front();
      if (taken !== p.taken) begin
        $error("predict_taken mismatch: expected %0b, actual %0b", p.taken, taken);
        errors++;
      end
      if (target !== p.target) begin
        $error("predict_target mismatch: expected %h, actual %h", p.target, target);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = gbp_pkg::ACT_PREDICT;
  logic [63:0] inst_addr = '0;
  logic [1:0]  inst_kind = gbp_pkg::KIND_COND;
  logic        was_taken = 1'b0;
  logic [63:0] next_addr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        predict_taken;
  logic [63:0] predict_target;

  bp_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int hot_idx[16];
  bit [63:0] addr_pool[8];

  gshare_branch_predictor #(
    .TARGET_ENTRIES(TARGET_ENTRIES),
    .COUNTER_ENTRIES(COUNTER_ENTRIES),
    .HISTORY_BITS(HISTORY_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .inst_addr(inst_addr),
    .inst_kind(inst_kind),
    .was_taken(was_taken),
    .next_addr(next_addr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .predict_taken(predict_taken),
    .predict_target(predict_target)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_item(action, inst_addr, inst_kind, was_taken, next_addr);
      end
      if (out_valid && !out_stall) sb.check_result(predict_taken, predict_target);
    end
  end

  // The receiver stalls at random, or for a long stretch when asked.
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // A non-negative aim places the item on that counter under the current history.
  task automatic send_item(bit act, bit [63:0] addr, bit [1:0] kind, bit tk,
                           bit [63:0] dest, int aim);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    if (aim >= 0) addr[CIDX_W-1:0] = CIDX_W'(aim) ^ CIDX_W'(sb.history);
    in_valid = 1'b1;
    action = act;
    inst_addr = addr;
    inst_kind = kind;
    was_taken = tk;
    next_addr = dest;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_training(int idx);
    int n;
    int bias;
    bit [1:0] kind;
    n = $urandom_range(1, 5);
    bias = $urandom_range(0, 100);
    repeat (n) begin
      kind = ($urandom_range(99) < 85) ? gbp_pkg::KIND_COND : 2'($urandom_range(1, 3));
      send_item(gbp_pkg::ACT_UPDATE, rand64(), kind, $urandom_range(99) < bias, rand64(),
                idx);
    end
    case ($urandom_range(9))
      0: kind = gbp_pkg::KIND_UNCOND;
      1: kind = KIND_OTHER;
      2: kind = KIND_SPARE;
      default: kind = gbp_pkg::KIND_COND;
    endcase
    send_item(gbp_pkg::ACT_PREDICT, rand64(), kind, 1'($urandom_range(1)), rand64(), idx);
  endtask

  task automatic run_phase(int sidle, int ridle, int count, bit with_hold);
    int stop_at;
    int pick;
    bit [63:0] addr;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    stop_at = items_sent + count;
    if (with_hold) begin
      hold_reqs++;
      repeat (40) begin
        send_item(gbp_pkg::ACT_PREDICT, addr_pool[$urandom_range(7)], gbp_pkg::KIND_UNCOND,
                  1'b0, rand64(), -1);
      end
    end
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        run_training(($urandom_range(1)) ? hot_idx[$urandom_range(15)]
                                         : $urandom_range(COUNTER_ENTRIES - 1));
      end else if (pick < 85) begin
        case ($urandom_range(3))
          0: addr = addr_pool[$urandom_range(7)];
          1: addr = ($urandom_range(1)) ? '1 : '0;
          default: addr = rand64();
        endcase
        send_item(1'($urandom_range(1)), addr, 2'($urandom_range(3)),
                  1'($urandom_range(1)), rand64(), -1);
      end else begin
        send_item(gbp_pkg::ACT_PREDICT, addr_pool[$urandom_range(7)], gbp_pkg::KIND_UNCOND,
                  1'($urandom_range(1)), rand64(), -1);
      end
    end
    drain_results();
  endtask

  initial begin
    foreach (hot_idx[i]) hot_idx[i] = $urandom_range(COUNTER_ENTRIES - 1);
    foreach (addr_pool[i]) addr_pool[i] = rand64();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(gbp_pkg::ACT_PREDICT, 64'h0, gbp_pkg::KIND_COND, 1'b0, 64'h0, -1);
    send_item(gbp_pkg::ACT_PREDICT, '1, gbp_pkg::KIND_UNCOND, 1'b1, '1, -1);
    send_item(gbp_pkg::ACT_PREDICT, 64'h8000_0000_0000_0000, KIND_OTHER, 1'b0, 64'h0, -1);
    send_item(gbp_pkg::ACT_PREDICT, 64'h5555_5555_5555_5555, KIND_SPARE, 1'b1, 64'h0, -1);
    send_item(gbp_pkg::ACT_UPDATE, '1, gbp_pkg::KIND_UNCOND, 1'b0, '1, -1);
    send_item(gbp_pkg::ACT_PREDICT, '1, gbp_pkg::KIND_UNCOND, 1'b0, 64'h0, -1);
    send_item(gbp_pkg::ACT_UPDATE, 64'h5, KIND_SPARE, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, -1);
    send_item(gbp_pkg::ACT_PREDICT, 64'h5, KIND_SPARE, 1'b0, 64'h0, -1);
    send_item(gbp_pkg::ACT_UPDATE, 64'h0, KIND_OTHER, 1'b1, 64'h1234_5678_9ABC_DEF0, -1);
    send_item(gbp_pkg::ACT_PREDICT, 64'h0, gbp_pkg::KIND_UNCOND, 1'b0, 64'h0, -1);
    // Saturate one counter upward and then back down, probing it each time.
    repeat (4) begin
      send_item(gbp_pkg::ACT_UPDATE, rand64(), gbp_pkg::KIND_COND, 1'b1, rand64(), 12'h123);
    end
    send_item(gbp_pkg::ACT_PREDICT, 64'h0, gbp_pkg::KIND_COND, 1'b0, 64'h0, 12'h123);
    repeat (4) begin
      send_item(gbp_pkg::ACT_UPDATE, rand64(), gbp_pkg::KIND_COND, 1'b0, rand64(), 12'h123);
    end
    send_item(gbp_pkg::ACT_PREDICT, '1, KIND_OTHER, 1'b0, 64'h0, 12'h123);
    repeat (2) begin
      send_item(gbp_pkg::ACT_UPDATE, rand64(), gbp_pkg::KIND_COND, 1'b1, '1, 12'h7FF);
    end
    send_item(gbp_pkg::ACT_PREDICT, 64'h0, KIND_SPARE, 1'b0, 64'h0, 12'h7FF);
    drain_results();

    run_phase(11, 62, 460, 1'b0);
    run_phase(62, 11, 460, 1'b0);
    run_phase(0, 0, 460, 1'b1);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/gbp_pkg.sv
sv/gbp_ram.sv
sv/gbp_ctrl.sv
sv/gshare_branch_predictor.sv
sv/gbp_check.sv
bench/gshare_branch_predictor_tb.sv
